FILE: hdl/rcpc_pkg.sv
//------------------------------------------------------------------------------
// RC pulse capture package
// Shared types and constants for the pulse capture controller and datapath.
//------------------------------------------------------------------------------
package rcpc_pkg;

	// Configuration port geometry.
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	// Register indexes, taken from paddr[3:2].
	localparam logic [1:0] REG_MIN_PULSE  = 2'd0;
	localparam logic [1:0] REG_MAX_PULSE  = 2'd1;
	localparam logic [1:0] REG_TIMEOUT    = 2'd2;
	localparam logic [1:0] REG_CHANNELS   = 2'd3;

	// Reset values of the configuration registers.
	localparam logic [15:0] MIN_PULSE_RST = 16'd1000;
	localparam logic [15:0] MAX_PULSE_RST = 16'd2000;
	localparam logic [19:0] TIMEOUT_RST   = 20'd100000;
	localparam logic [2:0]  CHANNELS_RST  = 3'd4;

	// Input action codes.
	localparam logic ACT_EDGE = 1'b0;
	localparam logic ACT_EVAL = 1'b1;

	// Position reported for a stale or empty channel (-1.0 in Q1.15).
	localparam logic signed [16:0] POS_INVALID = -17'sd32768;

	// Number of quotient bits produced by the serial divider.
	localparam int DIV_STEPS = 16;

	typedef struct packed {
		logic [15:0] min_pulse_us;
		logic [15:0] max_pulse_us;
		logic [19:0] timeout_us;
		logic [2:0]  channels_in_use;
	} cfg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_CLAMP,
		S_SETUP,
		S_DIV,
		S_FORM,
		S_OUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic edge_write;
		logic eval_start;
		logic check;
		logic clamp;
		logic setup;
		logic div_step;
		logic out_load;
		logic next_ch;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic eval_empty;
		logic skip_div;
		logic div_done;
		logic is_last;
	} status_t;

endpackage

FILE: hdl/rcpc_regs.sv
//------------------------------------------------------------------------------
// RC pulse capture configuration registers
// APB-style register file holding clamp limits, timeout and channel count.
//------------------------------------------------------------------------------
module rcpc_regs
	import rcpc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	// Register write on the access cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_pulse_us    <= MIN_PULSE_RST;
			cfg_q.max_pulse_us    <= MAX_PULSE_RST;
			cfg_q.timeout_us      <= TIMEOUT_RST;
			cfg_q.channels_in_use <= CHANNELS_RST;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_MIN_PULSE: cfg_q.min_pulse_us    <= pwdata[15:0];
				REG_MAX_PULSE: cfg_q.max_pulse_us    <= pwdata[15:0];
				REG_TIMEOUT:   cfg_q.timeout_us      <= pwdata[19:0];
				REG_CHANNELS:  cfg_q.channels_in_use <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	// Read data multiplexer.
	always_comb begin
		case (paddr[3:2])
			REG_MIN_PULSE: prdata = {16'd0, cfg_q.min_pulse_us};
			REG_MAX_PULSE: prdata = {16'd0, cfg_q.max_pulse_us};
			REG_TIMEOUT:   prdata = {12'd0, cfg_q.timeout_us};
			REG_CHANNELS:  prdata = {29'd0, cfg_q.channels_in_use};
			default:       prdata = '0;
		endcase
	end

endmodule

FILE: hdl/rcpc_datapath.sv
//------------------------------------------------------------------------------
// RC pulse capture datapath
// Per-channel stamp and width storage, validity check, clamp, serial divider
// and the result register.
//------------------------------------------------------------------------------
module rcpc_datapath
	import rcpc_pkg::*;
#(
	parameter int CHANNELS = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  cmd_t               cmd,
	output status_t            status,
	input  logic [1:0]         channel,
	input  logic               level,
	input  logic [31:0]        now_us,
	output logic [1:0]         out_channel,
	output logic [15:0]        pulse_us,
	output logic signed [16:0] position,
	output logic               valid_res,
	output logic               last
);

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [3:0] CH_LIM = 4'(CHANNELS);
	localparam logic [3:0] STEP_LAST = 4'(DIV_STEPS - 1);

	logic [31:0] rise_stamp_q   [CHANNELS];
	logic [15:0] pulse_width_q  [CHANNELS];
	logic [31:0] update_stamp_q [CHANNELS];

	logic [IDX_W-1:0] ch_q;
	logic [31:0]      now_q;
	logic             invalid_q;
	logic             span_ok_q;
	logic             skip_q;
	logic [15:0]      pw_q;
	logic [16:0]      rem_q;
	logic [15:0]      div_q;
	logic [15:0]      quo_q;
	logic [3:0]       step_q;

	logic [IDX_W-1:0] edge_idx;
	logic             edge_in_range;
	logic [31:0]      edge_width;
	logic [15:0]      edge_sat;
	logic [3:0]       n_report;
	logic [31:0]      age;
	logic             rem_ge;
	logic [16:0]      rem_sub;

	// Edge handling: width since the stored rise, saturated to 16 bits.
	assign edge_idx      = IDX_W'(channel);
	assign edge_in_range = ({2'b00, channel} < CH_LIM);
	assign edge_width    = now_us - rise_stamp_q[edge_idx];
	assign edge_sat      = (|edge_width[31:16]) ? 16'hFFFF : edge_width[15:0];

	// Channels reported per evaluate, limited to the built channel count.
	assign n_report = ({1'b0, cfg.channels_in_use} > CH_LIM) ? CH_LIM
	                                                         : {1'b0, cfg.channels_in_use};

	// Age of the current channel's last update, wrapping.
	assign age = now_q - update_stamp_q[ch_q];

	// One restoring division step.
	assign rem_ge  = (rem_q >= {1'b0, div_q});
	assign rem_sub = rem_ge ? (rem_q - {1'b0, div_q}) : rem_q;

	assign status.eval_empty = (n_report == 4'd0);
	assign status.skip_div   = skip_q;
	assign status.div_done   = (step_q == STEP_LAST);
	assign status.is_last    = ((4'(ch_q) + 4'd1) == n_report);

	// Channel storage, cleared at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				rise_stamp_q[i]   <= '0;
				pulse_width_q[i]  <= '0;
				update_stamp_q[i] <= '0;
			end
		end else if (cmd.edge_write && edge_in_range) begin
			if (level) begin
				rise_stamp_q[edge_idx] <= now_us;
			end else begin
				pulse_width_q[edge_idx]  <= edge_sat;
				update_stamp_q[edge_idx] <= now_us;
			end
		end
	end

	// Channel index for the evaluate walk.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q <= '0;
		end else if (cmd.eval_start) begin
			ch_q <= '0;
		end else if (cmd.next_ch) begin
			ch_q <= ch_q + IDX_W'(1);
		end
	end

	// Divider step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.setup) begin
			step_q <= '0;
		end else if (cmd.div_step) begin
			step_q <= step_q + 4'd1;
		end
	end

	// Per-channel arithmetic: check, clamp, setup and divide.
	always_ff @(posedge clk) begin
		if (cmd.eval_start) begin
			now_q <= now_us;
		end
		if (cmd.check) begin
			invalid_q <= (age > {12'd0, cfg.timeout_us}) || (pulse_width_q[ch_q] == 16'd0);
			pw_q      <= (pulse_width_q[ch_q] < cfg.min_pulse_us) ? cfg.min_pulse_us
			                                                      : pulse_width_q[ch_q];
		end
		if (cmd.clamp) begin
			pw_q <= (pw_q > cfg.max_pulse_us) ? cfg.max_pulse_us : pw_q;
		end
		if (cmd.setup) begin
			span_ok_q <= (cfg.max_pulse_us > cfg.min_pulse_us);
			skip_q    <= invalid_q || !(cfg.max_pulse_us > cfg.min_pulse_us);
			rem_q     <= {1'b0, pw_q - cfg.min_pulse_us};
			div_q     <= cfg.max_pulse_us - cfg.min_pulse_us;
			quo_q     <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= {rem_sub[15:0], 1'b0};
			quo_q <= {quo_q[14:0], rem_ge};
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_channel <= 2'(ch_q);
			last        <= status.is_last;
			valid_res   <= !invalid_q;
			if (invalid_q) begin
				pulse_us <= '0;
				position <= POS_INVALID;
			end else begin
				pulse_us <= pw_q;
				position <= span_ok_q ? $signed({1'b0, quo_q}) : 17'sd0;
			end
		end
	end

endmodule

FILE: hdl/rcpc_ctrl.sv
//------------------------------------------------------------------------------
// RC pulse capture controller
// Sequences edge updates and the per-channel evaluate walk.
//------------------------------------------------------------------------------
module rcpc_ctrl
	import rcpc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  logic    action,
	output logic    out_valid,
	input  logic    out_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (action == ACT_EDGE) begin
						cmd.edge_write = 1'b1;
					end else begin
						cmd.eval_start = 1'b1;
						if (!status.eval_empty) begin
							state_d = S_CHECK;
						end
					end
				end
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				state_d   = S_CLAMP;
			end
			S_CLAMP: begin
				cmd.clamp = 1'b1;
				state_d   = S_SETUP;
			end
			S_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = S_DIV;
			end
			S_DIV: begin
				if (status.skip_div) begin
					state_d = S_FORM;
				end else begin
					cmd.div_step = 1'b1;
					if (status.div_done) begin
						state_d = S_FORM;
					end
				end
			end
			S_FORM: begin
				cmd.out_load = 1'b1;
				state_d      = S_OUT;
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (status.is_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.next_ch = 1'b1;
						state_d     = S_CHECK;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

FILE: hdl/rc_pulse_capture_normalizer.sv
//------------------------------------------------------------------------------
// RC pulse capture normalizer
// Captures RC pulse widths per channel and reports clamped widths and
// normalized Q1.15 positions on request.
//------------------------------------------------------------------------------
// An edge request is taken in the idle state and produces no result. An evaluate
// request walks the channels in use one at a time; each valid channel with a
// nonzero clamp span passes check, clamp, setup, the one-bit-per-cycle
// restoring divider and the result load, while a stale or empty channel or a
// zero span skips the divider steps; each result then waits for out_ready.
// The next request is taken once the last result is delivered.
module rc_pulse_capture_normalizer
	import rcpc_pkg::*;
#(
	parameter int CHANNELS = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               action,
	input  logic [1:0]         channel,
	input  logic               level,
	input  logic [31:0]        now_us,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         out_channel,
	output logic [15:0]        pulse_us,
	output logic signed [16:0] position,
	output logic               valid_res,
	output logic               last
);

	cfg_t    cfg;
	cmd_t    cmd;
	status_t status;

	rcpc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rcpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	rcpc_datapath #(
		.CHANNELS (CHANNELS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmd         (cmd),
		.status      (status),
		.channel     (channel),
		.level       (level),
		.now_us      (now_us),
		.out_channel (out_channel),
		.pulse_us    (pulse_us),
		.position    (position),
		.valid_res   (valid_res),
		.last        (last)
	);

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// RC pulse capture normalizer testbench
// Sends edge and evaluate requests to the block and predicts every channel
// result with a behavioral copy of the capture and normalization logic. Each
// delivered result is compared field by field with the oldest prediction.
// Directed tests come first, then random pulse traffic under several settings,
// a run with no idling, and a long output stall that backs up the input.
//------------------------------------------------------------------------------
module testbench
	import rcpc_pkg::*;
();

	localparam int NUM_CH        = 4;
	localparam int STALL_CYCLES  = 400;
	localparam int SETTLE_CYCLES = 32;
	localparam int LIMIT_CYCLES  = 400000;

	// One predicted channel result.
	typedef struct packed {
		logic [1:0]         chan;
		logic [15:0]        width;
		logic signed [16:0] pos;
		logic               ok;
		logic               fin;
	} reading_t;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              psel     = 1'b0;
	logic              penable  = 1'b0;
	logic              pwrite   = 1'b0;
	logic [ADDR_W-1:0] paddr    = '0;
	logic [DATA_W-1:0] pwdata   = '0;
	logic              in_valid = 1'b0;
	logic              action   = ACT_EDGE;
	logic [1:0]        channel  = '0;
	logic              level    = 1'b0;
	logic [31:0]       now_us   = '0;
	logic              out_ready = 1'b0;

	logic [DATA_W-1:0]  prdata;
	logic               pready;
	logic               in_ready;
	logic               out_valid;
	logic [1:0]         out_channel;
	logic [15:0]        pulse_us;
	logic signed [16:0] position;
	logic               valid_res;
	logic               last;

	// Predictor state and configuration.
	logic [31:0] rise_at  [NUM_CH];
	logic [15:0] width_of [NUM_CH];
	logic [31:0] fall_at  [NUM_CH];
	cfg_t        model_cfg;
	reading_t    pending_readings[$];

	int          errors          = 0;
	int          requests_sent   = 0;
	int          evaluates_sent  = 0;
	int          readings_checked = 0;
	int          config_phases   = 0;
	int          cycle_count     = 0;
	bit          steady          = 1'b0;
	logic        rx_hold         = 1'b0;
	logic [31:0] stamp_us        = '0;

	rc_pulse_capture_normalizer #(
		.CHANNELS(NUM_CH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.channel(channel),
		.level(level),
		.now_us(now_us),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_channel(out_channel),
		.pulse_us(pulse_us),
		.position(position),
		.valid_res(valid_res),
		.last(last)
	);

	always #4 clk = ~clk;

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles with %0d results outstanding",
				cycle_count, pending_readings.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		errors++;
		$display("ERROR cycle %0d: %s", cycle_count, what);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s is 0x%0h, expected 0x%0h",
				readings_checked, name, got, want));
	endtask

	// Updates the captured stamps for an edge request, or queues one reading
	// per reported channel for an evaluate request.
	function automatic void predict_request(input logic act, input logic [1:0] ch,
			input logic lvl, input logic [31:0] now);
		logic [31:0] span;
		logic [31:0] age;
		logic [31:0] lo;
		logic [31:0] hi;
		logic [31:0] pw;
		logic [47:0] quot;
		int          n;
		reading_t    r;
		if (act == ACT_EDGE) begin
			if (lvl) begin
				rise_at[ch] = now;
			end else begin
				span = now - rise_at[ch];
				width_of[ch] = (span > 32'hFFFF) ? 16'hFFFF : span[15:0];
				fall_at[ch] = now;
			end
			return;
		end
		n = int'(model_cfg.channels_in_use);
		if (n > NUM_CH)
			n = NUM_CH;
		lo = 32'(model_cfg.min_pulse_us);
		hi = 32'(model_cfg.max_pulse_us);
		for (int i = 0; i < n; i++) begin
			age = now - fall_at[i];
			r.chan = 2'(i);
			r.fin = (i == n - 1);
			if (age > 32'(model_cfg.timeout_us) || width_of[i] == '0) begin
				r.width = '0;
				r.pos = POS_INVALID;
				r.ok = 1'b0;
			end else begin
				// Clamp to the floor first, then to the ceiling.
				pw = 32'(width_of[i]);
				if (pw < lo)
					pw = lo;
				if (pw > hi)
					pw = hi;
				if (hi > lo)
					quot = (48'(pw - lo) << 15) / 48'(hi - lo);
				else
					quot = '0;
				r.width = pw[15:0];
				r.pos = quot[16:0];
				r.ok = 1'b1;
			end
			pending_readings.push_back(r);
		end
	endfunction

	// Result checker: every delivered result is matched with the oldest reading.
	always @(posedge clk) begin
		reading_t want;
		if (arst_n && out_valid && out_ready) begin
			readings_checked++;
			if (pending_readings.size() == 0) begin
				report_mismatch($sformatf("unexpected result for channel %0d",
					out_channel));
			end else begin
				want = pending_readings.pop_front();
				check_field("out_channel", out_channel, want.chan);
				check_field("pulse_us", pulse_us, want.width);
				check_field("position", position, want.pos);
				check_field("valid_res", valid_res, want.ok);
				check_field("last", last, want.fin);
			end
		end
	end

	// Output side: random stalls, none in steady mode, all during a hold.
	always @(posedge clk) begin
		if (rx_hold)
			out_ready <= 1'b0;
		else if (steady)
			out_ready <= 1'b1;
		else
			out_ready <= ($urandom_range(99) >= 25);
	end

	// Offers one request, holds it until accepted, then predicts its results.
	// Valid stays high afterwards so that back-to-back requests need no toggle.
	task automatic send_request(input logic act, input logic [1:0] ch, input logic lvl,
			input logic [31:0] now);
		if (!steady) begin
			while ($urandom_range(99) < 25) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		action <= act;
		channel <= ch;
		level <= lvl;
		now_us <= now;
		do
			@(posedge clk);
		while (!in_ready);
		predict_request(act, ch, lvl, now);
		requests_sent++;
		if (act == ACT_EVAL)
			evaluates_sent++;
	endtask

	task automatic pulse_pair(input logic [1:0] ch, input logic [31:0] t_rise,
			input logic [31:0] w);
		send_request(ACT_EDGE, ch, 1'b1, t_rise);
		send_request(ACT_EDGE, ch, 1'b0, t_rise + w);
	endtask

	// The channel and level fields of an evaluate are don't-care; randomize them.
	task automatic evaluate_at(input logic [31:0] now);
		send_request(ACT_EVAL, 2'($urandom), 1'($urandom), now);
	endtask

	// Drops valid, waits for all readings, then lets trailing work finish.
	task automatic finish_phase();
		in_valid <= 1'b0;
		while (pending_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register write: setup cycle, access cycle, then an idle cycle.
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_MIN_PULSE: model_cfg.min_pulse_us = value[15:0];
			REG_MAX_PULSE: model_cfg.max_pulse_us = value[15:0];
			REG_TIMEOUT:   model_cfg.timeout_us = value[19:0];
			REG_CHANNELS:  model_cfg.channels_in_use = value[2:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [15:0] lo, input logic [15:0] hi,
			input logic [19:0] tmo, input logic [2:0] chans);
		write_reg(REG_MIN_PULSE, 32'(lo));
		write_reg(REG_MAX_PULSE, 32'(hi));
		write_reg(REG_TIMEOUT, 32'(tmo));
		write_reg(REG_CHANNELS, 32'(chans));
		config_phases++;
	endtask

	task automatic random_config();
		case ($urandom_range(3))
			0: set_config(16'($urandom_range(900, 1100)), 16'($urandom_range(1900, 2100)),
				20'($urandom_range(20000, 20'hFFFFF)), 3'd4);
			1: set_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
				20'($urandom_range(0, 20'hFFFFF)), 3'($urandom_range(0, 7)));
			2: set_config(16'($urandom_range(0, 3000)), 16'($urandom_range(0, 3000)),
				20'($urandom_range(0, 5000)), 3'($urandom_range(1, 4)));
			default: set_config(16'($urandom_range(800, 1200)),
				16'($urandom_range(1800, 2200)),
				20'($urandom_range(50000, 200000)), 3'($urandom_range(0, 7)));
		endcase
	endtask

	// Mostly well-formed pulses and evaluates on a running timeline, with some
	// lone edges and edges at arbitrary times mixed in.
	task automatic random_burst(input int count);
		int          kind;
		logic [31:0] w;
		repeat (count) begin
			kind = $urandom_range(99);
			if (kind < 55) begin
				case ($urandom_range(9))
					0: w = $urandom_range(0, 100000);
					1: w = $urandom_range(0, 3);
					default: w = $urandom_range(700, 2300);
				endcase
				pulse_pair(2'($urandom), stamp_us, w);
				stamp_us += w + $urandom_range(0, 4000);
			end else if (kind < 80) begin
				if ($urandom_range(9) == 0)
					stamp_us += $urandom_range(0, 300000);
				evaluate_at(stamp_us);
				stamp_us += $urandom_range(0, 500);
			end else if (kind < 90) begin
				send_request(ACT_EDGE, 2'($urandom), 1'($urandom),
					stamp_us + $urandom_range(0, 2000));
			end else begin
				send_request(ACT_EDGE, 2'($urandom), 1'($urandom), $urandom);
			end
		end
	endtask

	// Right after reset every channel is empty, so all report invalid.
	task automatic test_empty_channels();
		evaluate_at(32'd0);
		finish_phase();
	endtask

	// Normal, short, saturated and zero widths, captured across the timer wrap.
	task automatic test_width_capture();
		logic [31:0] base;
		base = 32'hFFFF_F000;
		pulse_pair(2'd0, base, 32'd1500);
		pulse_pair(2'd1, base + 100, 32'd600);
		pulse_pair(2'd2, base + 200, 32'd70000);
		pulse_pair(2'd3, base + 300, 32'd0);
		evaluate_at(base + 70300);
		finish_phase();
	endtask

	// Age exactly at the timeout is still fresh; one more microsecond is stale.
	task automatic test_timeout_boundary();
		logic [31:0] base;
		base = 32'hFFFF_F000;
		evaluate_at(base + 1500 + 100000);
		evaluate_at(base + 1501 + 100000);
		evaluate_at(32'hFFFF_FFFF);
		send_request(ACT_EDGE, 2'd1, 1'b1, 32'd0);
		finish_phase();
	endtask

	// Full-range clamp, empty span, inverted limits, zero timeout and zero or
	// oversized channel counts.
	task automatic test_config_extremes();
		logic [31:0] t;
		t = 32'h0001_0000;
		set_config(16'd0, 16'hFFFF, 20'hFFFFF, 3'd7);
		pulse_pair(2'd0, t, 32'd1);
		pulse_pair(2'd1, t, 32'd40000);
		evaluate_at(t + 50000);
		finish_phase();
		set_config(16'd1500, 16'd1500, 20'hFFFFF, 3'd2);
		evaluate_at(t + 50001);
		finish_phase();
		set_config(16'hFFFF, 16'd0, 20'd0, 3'd1);
		pulse_pair(2'd0, t + 60000, 32'd1500);
		evaluate_at(t + 61500);
		finish_phase();
		set_config(MIN_PULSE_RST, MAX_PULSE_RST, TIMEOUT_RST, 3'd0);
		evaluate_at(t + 62000);
		finish_phase();
		set_config(MIN_PULSE_RST, MAX_PULSE_RST, TIMEOUT_RST, 3'd3);
		evaluate_at(t + 62000);
		finish_phase();
	endtask

	task automatic test_random_traffic();
		stamp_us = $urandom;
		for (int p = 0; p < 4; p++) begin
			if (p == 2)
				stamp_us = 32'hFFFF_C000;
			random_config();
			random_burst(15);
			finish_phase();
		end
	endtask

	// Neither side idles for a whole burst.
	task automatic test_back_to_back();
		set_config(MIN_PULSE_RST, MAX_PULSE_RST, 20'hFFFFF, 3'd4);
		steady = 1'b1;
		random_burst(15);
		finish_phase();
		steady = 1'b0;
	endtask

	// The output side stops for a long stretch while requests keep coming.
	task automatic test_output_backpressure();
		set_config(MIN_PULSE_RST, MAX_PULSE_RST, 20'hFFFFF, 3'd4);
		fork
			begin
				rx_hold <= 1'b1;
				repeat (STALL_CYCLES) @(posedge clk);
				rx_hold <= 1'b0;
			end
		join_none
		repeat (5) begin
			pulse_pair(2'($urandom), stamp_us, $urandom_range(900, 2100));
			stamp_us += 3000;
			evaluate_at(stamp_us);
		end
		finish_phase();
	endtask

	// Main sequence.
	initial begin
		model_cfg.min_pulse_us = MIN_PULSE_RST;
		model_cfg.max_pulse_us = MAX_PULSE_RST;
		model_cfg.timeout_us = TIMEOUT_RST;
		model_cfg.channels_in_use = CHANNELS_RST;
		foreach (rise_at[i]) begin
			rise_at[i] = '0;
			width_of[i] = '0;
			fall_at[i] = '0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_channels();
		test_width_capture();
		test_timeout_boundary();
		test_config_extremes();
		test_random_traffic();
		test_back_to_back();
		test_output_backpressure();

		$display("covered %0d requests (%0d evaluates) and %0d channel results",
			requests_sent, evaluates_sent, readings_checked);
		$display("over %0d register settings, a %0d-cycle output stall and a no-idle burst",
			config_phases, STALL_CYCLES);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: sim.f
hdl/rcpc_pkg.sv
hdl/rcpc_regs.sv
hdl/rcpc_datapath.sv
hdl/rcpc_ctrl.sv
hdl/rc_pulse_capture_normalizer.sv
bench/testbench.sv
